/* rtl/rcfr_pkg.sv */
// Package: shared types, constants and word formats of the RC frame receiver.
`timescale 1ns / 1ps
`default_nettype none
package rcfr_pkg;

  localparam int FRAME_BYTES = 18;
  localparam int FRAME_IDX_BITS = $clog2(FRAME_BYTES);
  localparam int COUNT_BITS = $clog2(FRAME_BYTES + 2);
  localparam int TICK_BITS = 16;
  localparam int STICK_BITS = 11;
  localparam int TIMEOUT_BITS = 16;
  localparam int CFG_DATA_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int TCMP_BITS = (TICK_BITS > TIMEOUT_BITS) ? TICK_BITS : TIMEOUT_BITS;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic [STICK_BITS-1:0] STICK_MIN_RST = 11'd364;
  localparam logic [STICK_BITS-1:0] STICK_MAX_RST = 11'd1684;
  localparam logic [STICK_BITS-1:0] STICK_CENTER_RST = 11'd1024;
  localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RST = 16'd50;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STICK_MIN = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STICK_MAX = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_STICK_CENTER = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TIMEOUT = 2'd3;

  // input op codes
  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_IDLE = 2'd1;
  localparam logic [1:0] OP_TICK = 2'd2;
  localparam logic [1:0] OP_POLL = 2'd3;

  typedef enum logic [1:0] {
    CMD_BYTE,
    CMD_IDLE,
    CMD_TICK,
    CMD_POLL
  } cmd_kind_t;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] data_byte;
  } in_word_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic [STICK_BITS-1:0] stick0;
    logic [STICK_BITS-1:0] stick1;
    logic [STICK_BITS-1:0] stick2;
    logic [STICK_BITS-1:0] stick3;
    logic [3:0]            switches;
    logic signed [15:0]    mouse_x;
    logic signed [15:0]    mouse_y;
    logic signed [15:0]    mouse_z;
    logic [15:0]           mouse_buttons;
    logic [15:0]           key_mask;
    logic signed [15:0]    wheel;
    logic                  link_lost;
  } out_word_t;

  // handshake between front queue and back executor
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage
`default_nettype wire

/* rtl/rcfr_front.sv */
// Front end: accepts input words, decodes the op and queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none
module rcfr_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire rcfr_pkg::in_word_t in_word,
  output rcfr_pkg::q_head_t      head,
  input  wire logic              pop
);
  import rcfr_pkg::*;

  cmd_t                 entries [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;
  logic                 push;
  logic                 do_pop;
  cmd_t                 cmd_in;

  always_comb begin
    cmd_in.data_byte = in_word.data_byte;
    unique case (in_word.op)
      OP_BYTE: cmd_in.kind = CMD_BYTE;
      OP_IDLE: cmd_in.kind = CMD_IDLE;
      OP_TICK: cmd_in.kind = CMD_TICK;
      OP_POLL: cmd_in.kind = CMD_POLL;
      default: cmd_in.kind = CMD_POLL;
    endcase
  end

  assign in_stall   = (count == QCNT_BITS'(QUEUE_DEPTH));
  assign push       = in_valid && !in_stall;
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

/* rtl/rcfr_back.sv */
// Back end: frame assembly, tick counter, failsafe check and output register.
`timescale 1ns / 1ps
`default_nettype none
module rcfr_back (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire rcfr_pkg::q_head_t                    head,
  output logic                                      pop,
  input  wire logic                                 cfg_we,
  input  wire logic [rcfr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [rcfr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output rcfr_pkg::out_word_t                       out_word
);
  import rcfr_pkg::*;

  logic [STICK_BITS-1:0]   stick_min;
  logic [STICK_BITS-1:0]   stick_max;
  logic [STICK_BITS-1:0]   stick_center;
  logic [TIMEOUT_BITS-1:0] timeout_ticks;

  logic [7:0]              frame_buffer [FRAME_BYTES];
  logic [COUNT_BITS-1:0]   byte_count;
  logic [STICK_BITS-1:0]   sticks [4];
  logic [3:0]              switches;
  logic [15:0]             mouse [3];
  logic [15:0]             buttons;
  logic [15:0]             keys;
  logic [15:0]             wheel;
  logic [TICK_BITS-1:0]    ticks;

  logic                    out_free;
  logic                    exec;
  logic                    lost;
  logic [STICK_BITS-1:0]   sticks_next [4];

  assign out_free = !out_valid || !out_stall;
  assign pop      = head.valid && ((head.cmd.kind != CMD_POLL) || out_free);
  assign exec     = pop;

  // failsafe check against the stored frame
  always_comb begin
    lost = (TCMP_BITS'(ticks) > TCMP_BITS'(timeout_ticks));
    for (int i = 0; i < 4; i++) begin
      if (sticks[i] < stick_min || sticks[i] > stick_max) lost = 1'b1;
    end
    for (int i = 0; i < 4; i++) begin
      sticks_next[i] = lost ? stick_center : sticks[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_min     <= STICK_MIN_RST;
      stick_max     <= STICK_MAX_RST;
      stick_center  <= STICK_CENTER_RST;
      timeout_ticks <= TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_STICK_MIN:    stick_min     <= cfg_data[STICK_BITS-1:0];
        CFG_STICK_MAX:    stick_max     <= cfg_data[STICK_BITS-1:0];
        CFG_STICK_CENTER: stick_center  <= cfg_data[STICK_BITS-1:0];
        CFG_TIMEOUT:      timeout_ticks <= cfg_data[TIMEOUT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // frame buffer: written in arrival order, no reset
  always_ff @(posedge clk) begin
    if (exec && head.cmd.kind == CMD_BYTE && byte_count < COUNT_BITS'(FRAME_BYTES)) begin
      frame_buffer[byte_count[FRAME_IDX_BITS-1:0]] <= head.cmd.data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      for (int i = 0; i < 4; i++) sticks[i] <= '0;
      switches   <= '0;
      for (int i = 0; i < 3; i++) mouse[i] <= '0;
      buttons    <= '0;
      keys       <= '0;
      wheel      <= '0;
      ticks      <= '0;
    end else if (exec) begin
      unique case (head.cmd.kind)
        CMD_BYTE: begin
          if (byte_count < COUNT_BITS'(FRAME_BYTES)) byte_count <= byte_count + 1'b1;
          else byte_count <= COUNT_BITS'(FRAME_BYTES + 1);
        end
        CMD_IDLE: begin
          if (byte_count == COUNT_BITS'(FRAME_BYTES)) begin
            sticks[0] <= {frame_buffer[1][2:0], frame_buffer[0]};
            sticks[1] <= {frame_buffer[2][5:0], frame_buffer[1][7:3]};
            sticks[2] <= {frame_buffer[4][0], frame_buffer[3], frame_buffer[2][7:6]};
            sticks[3] <= {frame_buffer[5][3:0], frame_buffer[4][7:1]};
            switches  <= frame_buffer[5][7:4];
            mouse[0]  <= {frame_buffer[7], frame_buffer[6]};
            mouse[1]  <= {frame_buffer[9], frame_buffer[8]};
            mouse[2]  <= {frame_buffer[11], frame_buffer[10]};
            buttons   <= {frame_buffer[13], frame_buffer[12]};
            keys      <= {frame_buffer[15], frame_buffer[14]};
            wheel     <= {frame_buffer[17], frame_buffer[16]};
            ticks     <= '0;
          end
          byte_count <= '0;
        end
        CMD_TICK: begin
          if (ticks != '1) ticks <= ticks + 1'b1;
        end
        CMD_POLL: begin
          for (int i = 0; i < 4; i++) sticks[i] <= sticks_next[i];
        end
        default: ;
      endcase
    end
  end

  // output register; a waiting result does not block non-poll words
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec && head.cmd.kind == CMD_POLL) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // link_lost here is the held lost flag of the last poll
  always_ff @(posedge clk) begin
    if (exec && head.cmd.kind == CMD_POLL) begin
      out_word.stick0        <= sticks_next[0];
      out_word.stick1        <= sticks_next[1];
      out_word.stick2        <= sticks_next[2];
      out_word.stick3        <= sticks_next[3];
      out_word.switches      <= switches;
      out_word.mouse_x       <= mouse[0];
      out_word.mouse_y       <= mouse[1];
      out_word.mouse_z       <= mouse[2];
      out_word.mouse_buttons <= buttons;
      out_word.key_mask      <= keys;
      out_word.wheel         <= wheel;
      out_word.link_lost     <= lost;
    end
  end

endmodule
`default_nettype wire

/* rtl/rc_frame_receiver_failsafe_unit.sv */
// Top level: RC frame receiver with link-loss failsafe.
// Takes one input word per clock unless stalled: bytes, line-idle marks, time ticks and polls.
// Words enter a four-deep command queue; the executor retires one word per clock unless a poll
// waits for the output register. A poll's result enters the output register when the poll
// executes; while that result waits under out_stall, non-poll words keep flowing and a further
// poll waits in the queue. in_stall rises only when the queue is full. Configuration writes
// take effect on the next clock and are expected only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module rc_frame_receiver_failsafe_unit (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire rcfr_pkg::in_word_t                  in_word,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output rcfr_pkg::out_word_t                      out_word,
  input  wire logic                                cfg_we,
  input  wire logic [rcfr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [rcfr_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import rcfr_pkg::*;

  q_head_t head;
  logic    pop;

  rcfr_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .head     (head),
    .pop      (pop)
  );

  rcfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

/* bench/rcfr_checker.sv */
// Checker: mirrors the RC frame receiver and compares every poll reply with its prediction.
`timescale 1ns / 1ps
module rcfr_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  rcfr_pkg::in_word_t                  in_word,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  rcfr_pkg::out_word_t                 out_word,
  input  logic                                cfg_we,
  input  logic [rcfr_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [rcfr_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  mismatches,
  output int                                  replies_owed,
  output int                                  replies_seen,
  output int                                  frames_taken
);
  import rcfr_pkg::*;

  // mirrored receiver state
  logic [7:0]              rx_buf [FRAME_BYTES];
  int                      rx_count;
  logic [STICK_BITS-1:0]   held_stick [4];
  logic [3:0]              held_sw;
  logic [15:0]             held_mouse [3];
  logic [15:0]             held_buttons;
  logic [15:0]             held_keys;
  logic [15:0]             held_wheel;
  logic [TICK_BITS-1:0]    quiet_ticks;

  // mirrored registers
  logic [STICK_BITS-1:0]   lim_lo;
  logic [STICK_BITS-1:0]   lim_hi;
  logic [STICK_BITS-1:0]   lim_mid;
  logic [TIMEOUT_BITS-1:0] quiet_limit;

  out_word_t               replies_q [$];

  function automatic int field_diff(string nm, logic [15:0] want, logic [15:0] got);
    if (want === got) return 0;
    if (mismatches < 10) $display("  %s: expected %h, got %h", nm, want, got);
    return 1;
  endfunction

  task automatic check_reply(out_word_t got);
    out_word_t want;
    int bad;
    if (replies_q.size() == 0) begin
      if (mismatches < 10) $display("%0t: poll reply %h with none pending", $time, got);
      mismatches++;
      return;
    end
    want = replies_q.pop_front();
    if (mismatches < 10 && want !== got)
      $display("%0t: poll reply %0d differs", $time, replies_seen);
    bad = field_diff("stick0", 16'(want.stick0), 16'(got.stick0))
        + field_diff("stick1", 16'(want.stick1), 16'(got.stick1))
        + field_diff("stick2", 16'(want.stick2), 16'(got.stick2))
        + field_diff("stick3", 16'(want.stick3), 16'(got.stick3))
        + field_diff("switches", 16'(want.switches), 16'(got.switches))
        + field_diff("mouse_x", want.mouse_x, got.mouse_x)
        + field_diff("mouse_y", want.mouse_y, got.mouse_y)
        + field_diff("mouse_z", want.mouse_z, got.mouse_z)
        + field_diff("mouse_buttons", want.mouse_buttons, got.mouse_buttons)
        + field_diff("key_mask", want.key_mask, got.key_mask)
        + field_diff("wheel", want.wheel, got.wheel)
        + field_diff("link_lost", 16'(want.link_lost), 16'(got.link_lost));
    if (bad != 0) mismatches++;
    replies_seen++;
  endtask

  task automatic take_word(in_word_t w);
    logic [47:0] head;
    logic        lost;
    out_word_t   rep;
    int          k;
    case (w.op)
      OP_BYTE: begin
        // bytes past a full frame are dropped and spoil the frame
        if (rx_count < FRAME_BYTES) begin
          rx_buf[rx_count] = w.data_byte;
          rx_count++;
        end else begin
          rx_count = FRAME_BYTES + 1;
        end
      end
      OP_IDLE: begin
        if (rx_count == FRAME_BYTES) begin
          head = {rx_buf[5], rx_buf[4], rx_buf[3], rx_buf[2], rx_buf[1], rx_buf[0]};
          held_stick[0] = head[10:0];
          held_stick[1] = head[21:11];
          held_stick[2] = head[32:22];
          held_stick[3] = head[43:33];
          held_sw       = head[47:44];
          held_mouse[0] = {rx_buf[7], rx_buf[6]};
          held_mouse[1] = {rx_buf[9], rx_buf[8]};
          held_mouse[2] = {rx_buf[11], rx_buf[10]};
          held_buttons  = {rx_buf[13], rx_buf[12]};
          held_keys     = {rx_buf[15], rx_buf[14]};
          held_wheel    = {rx_buf[17], rx_buf[16]};
          quiet_ticks   = '0;
          frames_taken++;
        end
        rx_count = 0;
      end
      OP_TICK: begin
        if (quiet_ticks != '1) quiet_ticks++;
      end
      default: begin
        lost = (quiet_ticks > quiet_limit);
        for (k = 0; k < 4; k++)
          if (held_stick[k] < lim_lo || held_stick[k] > lim_hi) lost = 1'b1;
        if (lost)
          for (k = 0; k < 4; k++) held_stick[k] = lim_mid;
        rep.stick0        = held_stick[0];
        rep.stick1        = held_stick[1];
        rep.stick2        = held_stick[2];
        rep.stick3        = held_stick[3];
        rep.switches      = held_sw;
        rep.mouse_x       = held_mouse[0];
        rep.mouse_y       = held_mouse[1];
        rep.mouse_z       = held_mouse[2];
        rep.mouse_buttons = held_buttons;
        rep.key_mask      = held_keys;
        rep.wheel         = held_wheel;
        rep.link_lost     = lost;
        replies_q.push_back(rep);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rx_count     = 0;
      for (int k = 0; k < 4; k++) held_stick[k] = '0;
      for (int k = 0; k < 3; k++) held_mouse[k] = '0;
      held_sw      = '0;
      held_buttons = '0;
      held_keys    = '0;
      held_wheel   = '0;
      quiet_ticks  = '0;
      lim_lo       = STICK_MIN_RST;
      lim_hi       = STICK_MAX_RST;
      lim_mid      = STICK_CENTER_RST;
      quiet_limit  = TIMEOUT_RST;
      replies_q.delete();
      mismatches   = 0;
      replies_seen = 0;
      frames_taken = 0;
    end else begin
      if (out_valid && !out_stall) check_reply(out_word);
      if (in_valid && !in_stall) take_word(in_word);
      if (cfg_we) begin
        case (cfg_index)
          CFG_STICK_MIN:    lim_lo = cfg_data[STICK_BITS-1:0];
          CFG_STICK_MAX:    lim_hi = cfg_data[STICK_BITS-1:0];
          CFG_STICK_CENTER: lim_mid = cfg_data[STICK_BITS-1:0];
          default:          quiet_limit = cfg_data[TIMEOUT_BITS-1:0];
        endcase
      end
    end
    replies_owed = replies_q.size();
  end

endmodule

/* bench/testbench.sv */
// Testbench top: drives frames, ticks and polls into the RC frame receiver and gives the verdict.
`timescale 1ns / 1ps
module testbench;
  import rcfr_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE      = QUEUE_DEPTH + 6;
  localparam int PHASE_WORDS = 200;
  localparam int HOLD_CYCLES = 300;
  localparam int IMG_BYTES   = 26;

  logic                      clk;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  in_word_t                  in_word;
  logic                      out_valid;
  logic                      out_stall;
  out_word_t                 out_word;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  int mismatches;
  int replies_owed;
  int replies_seen;
  int frames_taken;

  int  tx_pct;
  int  rx_pct;
  bit  hold_req;
  int  words_sent;
  int  cfg_sets;
  int  cycles;

  logic [STICK_BITS-1:0]   cur_min;
  logic [STICK_BITS-1:0]   cur_max;
  logic [TIMEOUT_BITS-1:0] cur_tmo;
  logic [7:0]              frame_img [IMG_BYTES];

  // per-phase register settings; phase 6 is randomized at run time
  int ph_min [8] = '{364, 0, 2047, 1000, 2047, 200, 0, 364};
  int ph_max [8] = '{1684, 2047, 2047, 1100, 0, 1800, 0, 1684};
  int ph_mid [8] = '{1024, 0, 2047, 0, 1024, 2047, 0, 1024};
  int ph_tmo [8] = '{50, 1, 0, 20, 65535, 7, 0, 50};

  rc_frame_receiver_failsafe_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  rcfr_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_word      (in_word),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_word     (out_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .replies_owed (replies_owed),
    .replies_seen (replies_seen),
    .frames_taken (frames_taken)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver side: random stall, or a long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_pct);
      end
    end
  end

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_word(logic [1:0] op, logic [7:0] data);
    while ($urandom_range(0, 99) < tx_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= '{op: op, data_byte: data};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic drain_all();
    in_valid <= 1'b0;
    while (replies_owed != 0) @(negedge clk);
    // non-poll words may still sit in the queue
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_limits(logic [STICK_BITS-1:0] mn, logic [STICK_BITS-1:0] mx,
                            logic [STICK_BITS-1:0] ct, logic [TIMEOUT_BITS-1:0] tm);
    logic [4:0] junk;
    // unused upper bits of the stick register writes carry noise
    junk = 5'($urandom);
    write_reg(CFG_STICK_MIN, {junk, mn});
    junk = 5'($urandom);
    write_reg(CFG_STICK_MAX, {junk, mx});
    junk = 5'($urandom);
    write_reg(CFG_STICK_CENTER, {junk, ct});
    write_reg(CFG_TIMEOUT, tm);
    cur_min = mn;
    cur_max = mx;
    cur_tmo = tm;
    cfg_sets++;
  endtask

  task automatic build_image(bit in_range);
    logic [STICK_BITS-1:0] s [4];
    logic [47:0]           head;
    int                    pick;
    for (int i = 0; i < IMG_BYTES; i++) frame_img[i] = 8'($urandom);
    for (int k = 0; k < 4; k++) begin
      pick = $urandom_range(0, 9);
      if (!in_range || cur_min > cur_max) s[k] = 11'($urandom);
      else if (pick == 0) s[k] = cur_min;
      else if (pick == 1) s[k] = cur_max;
      else s[k] = 11'($urandom_range(cur_min, cur_max));
    end
    head = {4'($urandom), s[3], s[2], s[1], s[0]};
    for (int i = 0; i < 6; i++) frame_img[i] = head[8*i +: 8];
  endtask

  task automatic send_frame(int n);
    for (int i = 0; i < n; i++) send_word(OP_BYTE, frame_img[i]);
    send_word(OP_IDLE, 8'($urandom));
  endtask

  task automatic random_burst();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      build_image($urandom_range(0, 3) != 0);
      send_frame(FRAME_BYTES);
    end else if (kind < 65) begin
      build_image(1'b1);
      send_frame($urandom_range(0, FRAME_BYTES - 1));
    end else if (kind < 73) begin
      build_image(1'b1);
      send_frame($urandom_range(FRAME_BYTES + 1, IMG_BYTES));
    end else if (kind < 85) begin
      n = (cur_tmo <= 64) ? $urandom_range(0, cur_tmo + 3) : $urandom_range(0, 8);
      repeat (n) send_word(OP_TICK, 8'($urandom));
    end else begin
      repeat ($urandom_range(1, 4)) send_word(2'($urandom_range(0, 3)), 8'($urandom));
    end
    repeat ($urandom_range(0, 3)) send_word(OP_TICK, 8'($urandom));
    if ($urandom_range(0, 99) < 60) send_word(OP_POLL, 8'($urandom));
  endtask

  initial begin
    logic [47:0] head;
    int          goal;
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_word    = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    tx_pct     = 0;
    rx_pct     = 0;
    hold_req   = 1'b0;
    words_sent = 0;
    cfg_sets   = 0;
    cur_min    = STICK_MIN_RST;
    cur_max    = STICK_MAX_RST;
    cur_tmo    = TIMEOUT_RST;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: poll on reset state (zero sticks trip the failsafe), empty idle, tick,
    // then a frame with sticks on both range edges and extreme words
    send_word(OP_POLL, 8'hFF);
    send_word(OP_IDLE, 8'h00);
    send_word(OP_TICK, 8'hA5);
    head = {4'hF, cur_max, cur_min, cur_max, cur_min};
    for (int i = 0; i < 6; i++) frame_img[i] = head[8*i +: 8];
    frame_img[6]  = 8'h00; frame_img[7]  = 8'h80; frame_img[8]  = 8'hFF;
    frame_img[9]  = 8'h7F; frame_img[10] = 8'hFF; frame_img[11] = 8'hFF;
    frame_img[12] = 8'hFF; frame_img[13] = 8'h00; frame_img[14] = 8'h00;
    frame_img[15] = 8'hFF; frame_img[16] = 8'h01; frame_img[17] = 8'h80;
    send_frame(FRAME_BYTES);
    send_word(OP_POLL, 8'h5A);
    drain_all();

    ph_min[6] = $urandom_range(0, 2047);
    ph_max[6] = $urandom_range(0, 2047);
    ph_mid[6] = $urandom_range(0, 2047);
    ph_tmo[6] = $urandom_range(1, 300);

    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        tx_pct = 9;
        rx_pct = 71;
      end else if (p < 6) begin
        tx_pct = 71;
        rx_pct = 9;
      end else begin
        tx_pct = 0;
        rx_pct = 0;
      end
      set_limits(11'(ph_min[p]), 11'(ph_max[p]), 11'(ph_mid[p]), 16'(ph_tmo[p]));
      if (p == 0) begin
        // hold the output long enough for the queue to fill and stall the input
        hold_req = 1'b1;
        repeat (8) send_word(OP_POLL, 8'($urandom));
      end
      goal = words_sent + PHASE_WORDS;
      while (words_sent < goal) random_burst();
      drain_all();
    end

    $display("run: %0d words in, %0d frames unpacked, %0d poll replies checked",
             words_sent, frames_taken, replies_seen);
    $display("  over %0d register settings, short and long frames and a long output hold",
             cfg_sets);
    if (mismatches == 0 && replies_owed == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

/* filelist.f */
rtl/rcfr_pkg.sv
rtl/rcfr_front.sv
rtl/rcfr_back.sv
rtl/rc_frame_receiver_failsafe_unit.sv
bench/rcfr_checker.sv
bench/testbench.sv
